### design/trf_pkg.sv
// ----------------------------------------------------------------------------
// trf_pkg
// Shared sizes, codes, item and setup structures for the triangle fill
// rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package trf_pkg;

    // image geometry
    localparam int MAX_ROWS  = 256;
    localparam int MAX_COLS  = 256;
    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;

    // item field widths
    localparam int KIND_W    = 2;
    localparam int VERT_W    = 16;
    localparam int VAL_W     = 8;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    // arithmetic widths: vertex differences, products, edge accumulators
    localparam int MUL_W  = VERT_W + 2;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_DIM_RESET = 9'd256;

    // item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_DRAW  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2
    } t_kind;

    typedef logic signed [VERT_W-1:0] t_coord;

    // three vertices of a draw item
    typedef struct packed {
        t_coord a_row;
        t_coord a_col;
        t_coord b_row;
        t_coord b_col;
        t_coord c_row;
        t_coord c_col;
    } t_tri;

    // box, start values and steps of the edge numerators na, nb and ng
    typedef struct packed {
        logic [ROW_W-1:0]         row_lo;
        logic [ROW_W-1:0]         row_hi;
        logic [COL_W-1:0]         col_lo;
        logic [COL_W-1:0]         col_hi;
        logic                     empty;
        logic                     test_edges;
        logic                     det_neg;
        logic signed [ACC_W-1:0]  na0;
        logic signed [ACC_W-1:0]  nb0;
        logic signed [ACC_W-1:0]  ng0;
        logic signed [MUL_W-1:0]  na_dr;
        logic signed [MUL_W-1:0]  nb_dr;
        logic signed [MUL_W-1:0]  ng_dr;
        logic signed [MUL_W-1:0]  na_dk;
        logic signed [MUL_W-1:0]  nb_dk;
        logic signed [MUL_W-1:0]  ng_dk;
    } t_setup;

    // pixel write request from the scan unit
    typedef struct packed {
        logic             en;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_scan_wr;

    // last used row or column index from a size register
    function automatic int dim_last(logic [CFG_W-1:0] used, int max_dim);
        int v;
        v = int'(used);
        if (v < 1) begin
            v = 1;
        end
        if (v > max_dim) begin
            v = max_dim;
        end
        return v - 1;
    endfunction

endpackage

`default_nettype wire

### design/trf_image_mem.sv
// ----------------------------------------------------------------------------
// trf_image_mem
// Byte image store: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_image_mem (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [trf_pkg::ADDR_W-1:0] i_waddr,
    input  logic [trf_pkg::VAL_W-1:0]  i_wdata,
    input  logic                      i_re,
    input  logic [trf_pkg::ADDR_W-1:0] i_raddr,
    output logic [trf_pkg::VAL_W-1:0]  o_rdata
);
    import trf_pkg::*;

    logic [VAL_W-1:0] r_mem [MEM_DEPTH];
    logic [VAL_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### design/trf_setup.sv
// ----------------------------------------------------------------------------
// trf_setup
// Draw setup: bounding box, clamping, determinant and edge start values,
// using one shared multiplier over a short sequence of steps.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_setup (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  trf_pkg::t_tri             i_tri,
    input  logic [trf_pkg::ROW_W-1:0] i_row_last,
    input  logic [trf_pkg::COL_W-1:0] i_col_last,
    output logic                      o_done,
    output trf_pkg::t_setup           o_setup
);
    import trf_pkg::*;

    localparam int VW1 = VERT_W + 1;

    // multiplier step codes
    localparam logic [2:0] MS_DET_AB = 3'd0;
    localparam logic [2:0] MS_DET_BA = 3'd1;
    localparam logic [2:0] MS_NA_R   = 3'd2;
    localparam logic [2:0] MS_NA_K   = 3'd3;
    localparam logic [2:0] MS_NB_R   = 3'd4;
    localparam logic [2:0] MS_NB_K   = 3'd5;
    localparam logic [2:0] MS_FLUSH  = 3'd6;

    typedef enum logic [6:0] {
        SU_IDLE  = 7'b0000001,
        SU_BOUND = 7'b0000010,
        SU_CLAMP = 7'b0000100,
        SU_MUL   = 7'b0001000,
        SU_NG1   = 7'b0010000,
        SU_NG2   = 7'b0100000,
        SU_DONE  = 7'b1000000
    } t_su_state;

    function automatic t_coord min3(t_coord a, t_coord b, t_coord c);
        t_coord m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic t_coord max3(t_coord a, t_coord b, t_coord c);
        t_coord m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    t_su_state               r_state, n_state;
    logic [2:0]              r_step, n_step;
    logic [2:0]              r_tag;
    logic                    r_tag_vld;

    t_tri                    r_tri;
    logic                    r_general;
    logic signed [VW1-1:0]   r_rlo_raw, r_rhi_raw, r_klo_raw, r_khi_raw;
    logic signed [MUL_W-1:0] r_a1, r_b1, r_a2, r_b2, r_ga, r_gb;
    logic [ROW_W-1:0]        r_row_lo, r_row_hi;
    logic [COL_W-1:0]        r_col_lo, r_col_hi;
    logic                    r_empty;
    logic signed [MUL_W-1:0] r_dr, r_dk;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_det, r_na, r_nb, r_ng;
    logic                    r_det_nz;

    // bounding values of the latched vertices
    t_coord c_min_r, c_max_r, c_min_k, c_max_k;
    logic   c_same_row, c_same_col;

    always_comb begin
        c_min_r    = min3(r_tri.a_row, r_tri.b_row, r_tri.c_row);
        c_max_r    = max3(r_tri.a_row, r_tri.b_row, r_tri.c_row);
        c_min_k    = min3(r_tri.a_col, r_tri.b_col, r_tri.c_col);
        c_max_k    = max3(r_tri.a_col, r_tri.b_col, r_tri.c_col);
        c_same_row = (r_tri.a_row == r_tri.b_row) && (r_tri.b_row == r_tri.c_row);
        c_same_col = (r_tri.a_col == r_tri.b_col) && (r_tri.b_col == r_tri.c_col);
    end

    // clamp the box to the used image
    logic signed [VW1-1:0] c_rlast, c_klast, c_rlo, c_rhi, c_klo, c_khi;

    always_comb begin
        c_rlast = $signed(VW1'(i_row_last));
        c_klast = $signed(VW1'(i_col_last));
        c_rlo   = (r_rlo_raw < 0) ? '0 : r_rlo_raw;
        c_klo   = (r_klo_raw < 0) ? '0 : r_klo_raw;
        c_rhi   = (r_rhi_raw > c_rlast) ? c_rlast : r_rhi_raw;
        c_khi   = (r_khi_raw > c_klast) ? c_klast : r_khi_raw;
    end

    // shared multiplier operands
    logic signed [MUL_W-1:0]  c_op_x, c_op_y;
    logic signed [PROD_W-1:0] c_prod;

    always_comb begin
        c_op_x = '0;
        c_op_y = '0;
        case (r_step)
            MS_DET_AB: begin c_op_x = r_a1; c_op_y = r_b2; end
            MS_DET_BA: begin c_op_x = r_b1; c_op_y = r_a2; end
            MS_NA_R:   begin c_op_x = r_a1; c_op_y = r_dr; end
            MS_NA_K:   begin c_op_x = r_b1; c_op_y = r_dk; end
            MS_NB_R:   begin c_op_x = r_a2; c_op_y = r_dr; end
            MS_NB_K:   begin c_op_x = r_b2; c_op_y = r_dk; end
            default:   begin c_op_x = '0;   c_op_y = '0;   end
        endcase
        c_prod = c_op_x * c_op_y;
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            SU_IDLE: begin
                if (i_start) begin
                    n_state = SU_BOUND;
                end
            end
            SU_BOUND: n_state = SU_CLAMP;
            SU_CLAMP: begin
                n_state = SU_MUL;
                n_step  = MS_DET_AB;
            end
            SU_MUL: begin
                n_step = r_step + 3'd1;
                if (r_step == MS_FLUSH) begin
                    n_state = SU_NG1;
                end
            end
            SU_NG1:  n_state = SU_NG2;
            SU_NG2:  n_state = SU_DONE;
            SU_DONE: n_state = SU_IDLE;
            default: n_state = SU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= SU_IDLE;
            r_step    <= MS_DET_AB;
            r_tag_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_tag_vld <= (r_state == SU_MUL);
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_tag  <= r_step;
        r_prod <= c_prod;

        if (r_state == SU_IDLE && i_start) begin
            r_tri <= i_tri;
        end

        // box corners and vertex differences
        if (r_state == SU_BOUND) begin
            r_general <= !c_same_row && !c_same_col;
            r_rlo_raw <= VW1'(c_min_r) - VW1'(!c_same_row && !c_same_col);
            r_klo_raw <= VW1'(c_min_k) - VW1'(!c_same_row && !c_same_col);
            r_rhi_raw <= VW1'(c_max_r);
            r_khi_raw <= VW1'(c_max_k);
            r_a1      <= MUL_W'(r_tri.b_col) - MUL_W'(r_tri.c_col);
            r_b1      <= MUL_W'(r_tri.c_row) - MUL_W'(r_tri.b_row);
            r_a2      <= MUL_W'(r_tri.c_col) - MUL_W'(r_tri.a_col);
            r_b2      <= MUL_W'(r_tri.a_row) - MUL_W'(r_tri.c_row);
            r_ga      <= MUL_W'(r_tri.a_col) - MUL_W'(r_tri.b_col);
            r_gb      <= MUL_W'(r_tri.b_row) - MUL_W'(r_tri.a_row);
        end

        // clamped box and offsets of its first pixel from vertex c
        if (r_state == SU_CLAMP) begin
            r_row_lo <= ROW_W'(c_rlo);
            r_row_hi <= ROW_W'(c_rhi);
            r_col_lo <= COL_W'(c_klo);
            r_col_hi <= COL_W'(c_khi);
            r_empty  <= (c_rlo > c_rhi) || (c_klo > c_khi);
            r_dr     <= MUL_W'(c_rlo) - MUL_W'(r_tri.c_row);
            r_dk     <= MUL_W'(c_klo) - MUL_W'(r_tri.c_col);
        end

        // accumulate the product formed in the previous cycle
        if (r_tag_vld) begin
            case (r_tag)
                MS_DET_AB: r_det <= ACC_W'(r_prod);
                MS_DET_BA: r_det <= r_det - ACC_W'(r_prod);
                MS_NA_R:   r_na  <= ACC_W'(r_prod);
                MS_NA_K:   r_na  <= r_na + ACC_W'(r_prod);
                MS_NB_R:   r_nb  <= ACC_W'(r_prod);
                MS_NB_K:   r_nb  <= r_nb + ACC_W'(r_prod);
                default:   ;
            endcase
        end

        // third numerator from the determinant
        if (r_state == SU_NG1) begin
            r_ng     <= r_det - r_na;
            r_det_nz <= (r_det != '0);
        end
        if (r_state == SU_NG2) begin
            r_ng <= r_ng - r_nb;
        end
    end

    assign o_done = (r_state == SU_DONE);

    always_comb begin
        o_setup.row_lo     = r_row_lo;
        o_setup.row_hi     = r_row_hi;
        o_setup.col_lo     = r_col_lo;
        o_setup.col_hi     = r_col_hi;
        o_setup.empty      = r_empty;
        o_setup.test_edges = r_general && r_det_nz;
        o_setup.det_neg    = r_det[ACC_W-1];
        o_setup.na0        = r_na;
        o_setup.nb0        = r_nb;
        o_setup.ng0        = r_ng;
        o_setup.na_dr      = r_a1;
        o_setup.nb_dr      = r_a2;
        o_setup.ng_dr      = r_ga;
        o_setup.na_dk      = r_b1;
        o_setup.nb_dk      = r_b2;
        o_setup.ng_dk      = r_gb;
    end

endmodule

`default_nettype wire

### design/trf_scan.sv
// ----------------------------------------------------------------------------
// trf_scan
// Pixel walker: visits the clamped box row by row, one pixel per cycle,
// stepping the edge numerators na, nb and ng by addition and issuing writes.
// ----------------------------------------------------------------------------
`default_nettype none

module trf_scan (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  trf_pkg::t_setup   i_setup,
    output trf_pkg::t_scan_wr o_wr,
    output logic              o_done
);
    import trf_pkg::*;

    typedef enum logic [1:0] {
        SC_IDLE = 2'b01,
        SC_RUN  = 2'b10
    } t_sc_state;

    function automatic logic agrees(logic signed [ACC_W-1:0] n, logic det_neg);
        return (n == '0) || (n[ACC_W-1] == det_neg);
    endfunction

    t_sc_state               r_state;
    logic [ROW_W-1:0]        r_row;
    logic [COL_W-1:0]        r_col;
    logic signed [ACC_W-1:0] r_ra, r_rb, r_rg;
    logic signed [ACC_W-1:0] r_ca, r_cb, r_cg;

    logic                    c_cover, c_last_col, c_last;
    logic signed [ACC_W-1:0] c_ra_nx, c_rb_nx, c_rg_nx;

    // coverage test and end of row / box
    always_comb begin
        c_cover    = !i_setup.test_edges ||
                     (agrees(r_ca, i_setup.det_neg) &&
                      agrees(r_cb, i_setup.det_neg) &&
                      agrees(r_cg, i_setup.det_neg));
        c_last_col = (r_col == i_setup.col_hi);
        c_last     = c_last_col && (r_row == i_setup.row_hi);
        c_ra_nx    = r_ra + ACC_W'(i_setup.na_dr);
        c_rb_nx    = r_rb + ACC_W'(i_setup.nb_dr);
        c_rg_nx    = r_rg + ACC_W'(i_setup.ng_dr);
    end

    // walker control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SC_IDLE;
        end else begin
            unique case (r_state)
                SC_IDLE: begin
                    if (i_start && !i_setup.empty) begin
                        r_state <= SC_RUN;
                    end
                end
                SC_RUN: begin
                    if (c_last) begin
                        r_state <= SC_IDLE;
                    end
                end
                default: r_state <= SC_IDLE;
            endcase
        end
    end

    // position and numerators
    always_ff @(posedge i_clk) begin
        if (r_state == SC_IDLE) begin
            r_row <= i_setup.row_lo;
            r_col <= i_setup.col_lo;
            r_ra  <= i_setup.na0;
            r_rb  <= i_setup.nb0;
            r_rg  <= i_setup.ng0;
            r_ca  <= i_setup.na0;
            r_cb  <= i_setup.nb0;
            r_cg  <= i_setup.ng0;
        end else if (c_last_col) begin
            r_row <= r_row + 1'b1;
            r_col <= i_setup.col_lo;
            r_ra  <= c_ra_nx;
            r_rb  <= c_rb_nx;
            r_rg  <= c_rg_nx;
            r_ca  <= c_ra_nx;
            r_cb  <= c_rb_nx;
            r_cg  <= c_rg_nx;
        end else begin
            r_col <= r_col + 1'b1;
            r_ca  <= r_ca + ACC_W'(i_setup.na_dk);
            r_cb  <= r_cb + ACC_W'(i_setup.nb_dk);
            r_cg  <= r_cg + ACC_W'(i_setup.ng_dk);
        end
    end

    always_comb begin
        o_wr.en  = (r_state == SC_RUN) && c_cover;
        o_wr.row = r_row;
        o_wr.col = r_col;
        o_done   = (r_state == SC_IDLE && i_start && i_setup.empty) ||
                   (r_state == SC_RUN && c_last);
    end

endmodule

`default_nettype wire

### design/triangle_fill_rasterizer.sv
// ----------------------------------------------------------------------------
// triangle_fill_rasterizer
// Byte image with triangle fill, pixel read and pixel write items.
//
//   channel   direction  handshake                   payload
//   in        input      i_in_valid / o_in_ready     kind, vertices, value, pixel
//   out       output     o_out_valid / i_out_ready   pixel_value
//   cfg       input      i_cfg_we                    i_cfg_idx, i_cfg_wdata
//
// After reset the image is swept to zero, one pixel a cycle, over all 2**ADDR_W
// addresses (65536 for a 256 by 256 image); no item is taken meanwhile.
// A write item is written in its accept cycle; a read item waits in ST_READ
// until the out register is free. A draw item runs setup on the shared
// multiplier, then visits each pixel of its clamped box (single write port).
// One item is in work at a time; a finished read waits in the out register.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_fill_rasterizer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration
    input  logic                         i_cfg_we,
    input  logic [trf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [trf_pkg::CFG_W-1:0]    i_cfg_wdata,
    // input items
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [trf_pkg::KIND_W-1:0]   i_kind,
    input  logic signed [trf_pkg::VERT_W-1:0] i_vertex_a_row,
    input  logic signed [trf_pkg::VERT_W-1:0] i_vertex_a_col,
    input  logic signed [trf_pkg::VERT_W-1:0] i_vertex_b_row,
    input  logic signed [trf_pkg::VERT_W-1:0] i_vertex_b_col,
    input  logic signed [trf_pkg::VERT_W-1:0] i_vertex_c_row,
    input  logic signed [trf_pkg::VERT_W-1:0] i_vertex_c_col,
    input  logic [trf_pkg::VAL_W-1:0]    i_fill_value,
    input  logic [trf_pkg::PIX_W-1:0]    i_pixel_row,
    input  logic [trf_pkg::PIX_W-1:0]    i_pixel_col,
    // result items
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [trf_pkg::VAL_W-1:0]    o_pixel_value
);
    import trf_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_DRAW  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_rows_used, r_cols_used;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [VAL_W-1:0]  r_fill;
    logic              r_rd_inside;
    logic              r_out_valid, n_out_valid;
    logic [VAL_W-1:0]  r_out_data, n_out_data;

    logic [ROW_W-1:0]  c_row_last;
    logic [COL_W-1:0]  c_col_last;
    logic              c_accept, c_inside;
    t_kind             c_kind;
    logic [ADDR_W-1:0] c_pix_addr;
    t_tri              c_tri;

    logic              su_done;
    t_setup            su_setup;
    t_scan_wr          sc_wr;
    logic              sc_done;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr;
    logic [VAL_W-1:0]  mem_wdata, mem_rdata;

    // size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_used <= CFG_DIM_RESET;
            r_cols_used <= CFG_DIM_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ROWS_USED: r_rows_used <= i_cfg_wdata;
                CFG_COLS_USED: r_cols_used <= i_cfg_wdata;
                default:       ;
            endcase
        end
    end

    // item decode
    always_comb begin
        c_row_last = ROW_W'(dim_last(r_rows_used, MAX_ROWS));
        c_col_last = COL_W'(dim_last(r_cols_used, MAX_COLS));
        o_in_ready = (r_state == ST_IDLE);
        c_accept   = i_in_valid && o_in_ready;
        c_kind     = t_kind'(i_kind);
        c_inside   = (32'(i_pixel_row) <= 32'(c_row_last)) &&
                     (32'(i_pixel_col) <= 32'(c_col_last));
        c_pix_addr = {ROW_W'(i_pixel_row), COL_W'(i_pixel_col)};
        c_tri      = '{a_row: i_vertex_a_row, a_col: i_vertex_a_col,
                       b_row: i_vertex_b_row, b_col: i_vertex_b_col,
                       c_row: i_vertex_c_row, c_col: i_vertex_c_col};
    end

    // control sequence and out register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (c_accept) begin
                    case (c_kind)
                        KIND_DRAW: n_state = ST_DRAW;
                        KIND_READ: n_state = ST_READ;
                        default:   n_state = ST_IDLE;
                    endcase
                end
            end
            ST_READ: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_rd_inside ? mem_rdata : '0;
                    n_state     = ST_IDLE;
                end
            end
            ST_DRAW: begin
                if (sc_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // item payload kept for the work in progress
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        if (c_accept) begin
            r_fill      <= i_fill_value;
            r_rd_inside <= c_inside;
        end
    end

    // memory port selection: clearing sweep, draw pixels, pixel writes
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = c_pix_addr;
        mem_wdata = i_fill_value;
        if (r_state == ST_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr_addr;
            mem_wdata = '0;
        end else if (sc_wr.en) begin
            mem_we    = 1'b1;
            mem_waddr = {sc_wr.row, sc_wr.col};
            mem_wdata = r_fill;
        end else if (c_accept && c_kind == KIND_WRITE && c_inside) begin
            mem_we    = 1'b1;
        end
        mem_re = c_accept && (c_kind == KIND_READ);
    end

    trf_setup u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (c_accept && (c_kind == KIND_DRAW)),
        .i_tri      (c_tri),
        .i_row_last (c_row_last),
        .i_col_last (c_col_last),
        .o_done     (su_done),
        .o_setup    (su_setup)
    );

    trf_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (su_done),
        .i_setup (su_setup),
        .o_wr    (sc_wr),
        .o_done  (sc_done)
    );

    trf_image_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (c_pix_addr),
        .o_rdata (mem_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_pixel_value = r_out_data;

`ifndef NO_ASSERTIONS
    // draw pixels stay inside the used image
    a_scan_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_wr.en |-> (sc_wr.row <= c_row_last) && (sc_wr.col <= c_col_last))
        else $error("draw pixel outside used image");

    // no item is taken while a draw still writes
    a_no_write_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_wr.en |-> !c_accept)
        else $error("item accepted during draw scan");

    // a read with a free out register delivers in the next cycle
    a_read_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && !r_out_valid) |=> o_out_valid)
        else $error("read item not delivered");

    // setup finishes only for a draw in progress
    a_setup_in_draw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        su_done |-> (r_state == ST_DRAW))
        else $error("setup finished outside a draw");
`endif

endmodule

`default_nettype wire
